// ===== hdl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in rst.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define CHECK_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

`define CHECK_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define CHECK_ALWAYS(label, cond, msg)

`define CHECK_IMPLIES(label, ante, cons, msg)

`define CHECK_NEXT(label, ante, cons, msg)

`endif

`endif

// ===== hdl/prb_pkg.sv =====
// ---------------------------------------------------------------------------
// Page range bitmap package
// Types, codes and sizing constants shared by the bitmap modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package prb_pkg;

  localparam int MAP_PAGES_DEFAULT = 4096;
  localparam int WORD_BITS = 64;
  localparam int CFG_IDX_W = 2;

  localparam logic [1:0] KIND_QUERY     = 2'd0;
  localparam logic [1:0] KIND_MARK_USED = 2'd1;
  localparam logic [1:0] KIND_MARK_FREE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_REGION_BASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAGE_SHIFT  = 2'd1;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] address;
    logic [31:0] length_bytes;
  } req_t;

  typedef struct packed {
    logic range_free;
    logic out_of_range;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SUB,
    ST_SHIFT,
    ST_CHECK,
    ST_READ,
    ST_MODIFY,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic sub;
    logic shift;
    logic check;
    logic read;
    logic modify;
    logic clear;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic zero_len;
    logic range_bad;
    logic walk_last;
    logic clear_last;
  } status_t;

endpackage

`default_nettype wire

// ===== hdl/page_range_bitmap.sv =====
// ---------------------------------------------------------------------------
// Page range bitmap
// Page allocation map with one bit per page and range query and mark.
// ---------------------------------------------------------------------------
// A request on req carries a kind (query, mark used, mark free), a byte
// address and a byte length. Each request yields one response on rsp with
// range_free and out_of_range. Configuration writes on the cfg channel set
// region_base (index 0) and page_shift (index 1) and are always taken.
// A request is taken in ST_IDLE, then passes ST_SUB, ST_SHIFT and ST_CHECK for
// address and range arithmetic, then ST_READ and ST_MODIFY for each 64-bit
// map word it touches (registered memory read, then modify, with a write back
// for a mark), and ends in ST_DONE, which loads the response register. A
// request with zero length or an out-of-range span skips the word walk.
// The next request is taken while a response still waits in the output
// register; a stalled receiver holds a finished result until rsp_ready
// rises, and no further request is taken until it is delivered.
// After reset the map is cleared one word per cycle, all ceil(MAP_PAGES / 64)
// words, with req_ready low; configuration writes are taken meanwhile.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module page_range_bitmap #(
  parameter int MAP_PAGES = prb_pkg::MAP_PAGES_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [prb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                   cfg_data,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  prb_pkg::req_t                 req,
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output prb_pkg::rsp_t                 rsp
);

  prb_pkg::cmd_t    cmd;
  prb_pkg::status_t status;

  assign cfg_ready = 1'b1;

  prb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .status    (status),
    .cmd       (cmd)
  );

  prb_datapath #(
    .MAP_PAGES (MAP_PAGES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req),
    .cmd       (cmd),
    .status    (status),
    .rsp       (rsp)
  );

  `CHECK_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready, "request taken while busy")
  `CHECK_IMPLIES(a_flags_exclusive, rsp_valid, !(rsp.range_free && rsp.out_of_range), "free and out of range both set")
  `CHECK_IMPLIES(a_clear_after_reset, $past(rst), !req_ready, "request taken during map clear")

endmodule

`default_nettype wire

// ===== hdl/prb_ctrl.sv =====
// ---------------------------------------------------------------------------
// Page range bitmap controller
// Sequences reset clearing, range setup, the word walk and the response.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module prb_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  input  prb_pkg::status_t  status,
  output prb_pkg::cmd_t     cmd
);

  prb_pkg::state_t state;
  prb_pkg::state_t state_next;
  logic            rsp_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= prb_pkg::ST_CLEAR;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    unique case (state)
      prb_pkg::ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (status.clear_last) begin
          state_next = prb_pkg::ST_IDLE;
        end
      end
      prb_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = prb_pkg::ST_SUB;
        end
      end
      prb_pkg::ST_SUB: begin
        cmd.sub    = 1'b1;
        state_next = prb_pkg::ST_SHIFT;
      end
      prb_pkg::ST_SHIFT: begin
        cmd.shift  = 1'b1;
        state_next = prb_pkg::ST_CHECK;
      end
      prb_pkg::ST_CHECK: begin
        cmd.check = 1'b1;
        if (status.zero_len || status.range_bad) begin
          state_next = prb_pkg::ST_DONE;
        end else begin
          state_next = prb_pkg::ST_READ;
        end
      end
      prb_pkg::ST_READ: begin
        cmd.read   = 1'b1;
        state_next = prb_pkg::ST_MODIFY;
      end
      prb_pkg::ST_MODIFY: begin
        cmd.modify = 1'b1;
        if (status.walk_last) begin
          state_next = prb_pkg::ST_DONE;
        end else begin
          state_next = prb_pkg::ST_READ;
        end
      end
      prb_pkg::ST_DONE: begin
        if (!rsp_valid || rsp_ready) begin
          cmd.out_load = 1'b1;
          state_next   = prb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = prb_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      rsp_valid_next = 1'b1;
    end else if (rsp_ready) begin
      rsp_valid_next = 1'b0;
    end else begin
      rsp_valid_next = rsp_valid;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/prb_datapath.sv =====
// ---------------------------------------------------------------------------
// Page range bitmap datapath
// Configuration registers, page range arithmetic and the bitmap memory.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module prb_datapath #(
  parameter int MAP_PAGES = prb_pkg::MAP_PAGES_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [prb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [63:0]                     cfg_data,
  input  prb_pkg::req_t                   req,
  input  prb_pkg::cmd_t                   cmd,
  output prb_pkg::status_t                status,
  output prb_pkg::rsp_t                   rsp
);

  localparam int WB        = prb_pkg::WORD_BITS;
  localparam int MAP_WORDS = (MAP_PAGES + WB - 1) / WB;
  localparam int IDX_W     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int CNT_W     = $clog2(MAP_PAGES + 1);
  localparam int BIT_W     = $clog2(WB);

  localparam logic [63:0]      MAP_PAGES_64 = 64'(MAP_PAGES);
  localparam logic [CNT_W-1:0] MAP_PAGES_C  = CNT_W'(MAP_PAGES);
  localparam logic [IDX_W-1:0] LAST_WORD    = IDX_W'(MAP_WORDS - 1);

  logic [63:0]      region_base;
  logic [4:0]       page_shift;

  logic [1:0]       kind;
  logic [63:0]      address;
  logic [31:0]      length_bytes;
  logic             zero_len;

  logic [63:0]      diff;
  logic             borrow;
  logic [32:0]      len_sum;

  logic [CNT_W-1:0] first;
  logic             first_big;
  logic [32:0]      count;

  logic [CNT_W-1:0] pos;
  logic [CNT_W-1:0] left;
  logic [CNT_W-1:0] chunk;
  logic [WB-1:0]    mask;
  logic [IDX_W-1:0] word;

  logic             res_free;
  logic             res_oor;

  logic [WB-1:0]    mem [MAP_WORDS];
  logic [WB-1:0]    rdata;
  logic [IDX_W-1:0] clr_idx;

  logic [63:0]      first_full;
  logic [CNT_W-1:0] avail;
  logic             range_bad;
  logic             is_query;
  logic [CNT_W-1:0] room;
  logic [CNT_W-1:0] chunk_next;
  logic [BIT_W-1:0] bitpos;
  logic [BIT_W:0]   end_bit;
  logic [WB-1:0]    mask_next;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [WB-1:0]    mem_wdata;
  logic             hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      region_base <= '0;
      page_shift  <= 5'd12;
    end else if (cfg_write) begin
      case (cfg_index)
        prb_pkg::REG_REGION_BASE: region_base <= cfg_data;
        prb_pkg::REG_PAGE_SHIFT:  page_shift  <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  assign first_full = diff >> page_shift;
  assign avail      = MAP_PAGES_C - first;
  assign range_bad  = borrow || first_big || (count > 33'(avail));
  assign is_query   = (kind != prb_pkg::KIND_MARK_USED) && (kind != prb_pkg::KIND_MARK_FREE);

  assign bitpos     = pos[BIT_W-1:0];
  assign room       = CNT_W'(WB) - CNT_W'(bitpos);
  assign chunk_next = (left < room) ? left : room;
  assign end_bit    = (BIT_W + 1)'(bitpos) + (BIT_W + 1)'(chunk_next);
  assign mask_next  = ({WB{1'b1}} << bitpos) &
                      (end_bit[BIT_W] ? {WB{1'b1}} : ~({WB{1'b1}} << end_bit[BIT_W-1:0]));

  assign hit = (rdata & mask) != '0;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind         <= req.kind;
      address      <= req.address;
      length_bytes <= req.length_bytes;
      zero_len     <= (req.length_bytes == 32'd0);
    end
    if (cmd.sub) begin
      {borrow, diff} <= {1'b0, address} - {1'b0, region_base};
      len_sum        <= {1'b0, length_bytes} + ((33'd1 << page_shift) - 33'd1);
    end
    if (cmd.shift) begin
      first     <= first_full[CNT_W-1:0];
      first_big <= first_full >= MAP_PAGES_64;
      count     <= len_sum >> page_shift;
    end
    if (cmd.check) begin
      pos      <= first;
      left     <= count[CNT_W-1:0];
      res_oor  <= !zero_len && range_bad;
      res_free <= zero_len || (!range_bad && is_query);
    end
    if (cmd.read) begin
      chunk <= chunk_next;
      mask  <= mask_next;
    end
    if (cmd.modify) begin
      pos  <= pos + chunk;
      left <= left - chunk;
      if (hit) begin
        res_free <= 1'b0;
      end
    end
    if (cmd.out_load) begin
      rsp.range_free   <= res_free;
      rsp.out_of_range <= res_oor;
    end
  end

  assign word = IDX_W'(pos >> BIT_W);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = word;
    mem_wdata = rdata & ~mask;
    if (cmd.clear) begin
      mem_we    = 1'b1;
      mem_waddr = clr_idx;
      mem_wdata = '0;
    end else if (cmd.modify) begin
      mem_we = !is_query;
      if (kind == prb_pkg::KIND_MARK_USED) begin
        mem_wdata = rdata | mask;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.read) begin
      rdata <= mem[word];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (cmd.clear) begin
      clr_idx <= clr_idx + IDX_W'(1);
    end
  end

  assign status.zero_len   = zero_len;
  assign status.range_bad  = range_bad;
  assign status.walk_last  = (left == chunk);
  assign status.clear_last = (clr_idx == LAST_WORD);

endmodule

`default_nettype wire
